>>> rtl/bdmv_pkg.sv
// ----------------------------------------------------------------------------
// bdmv_pkg
// Shared constants for the block-diagonal matrix-vector unit: default sizes,
// input opcodes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package bdmv_pkg;

  localparam int DOF_MAX_DEF  = 8;
  localparam int NODE_MAX_DEF = 256;

  localparam int VALUE_W   = 32;
  localparam int ROW_IDX_W = 11;
  localparam int COL_IDX_W = 3;
  localparam int DOF_REG_W = 4;
  localparam int NOD_REG_W = 9;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int ACC_W     = 67;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  localparam logic REG_DOF   = 1'b0;
  localparam logic REG_NODES = 1'b1;

endpackage

>>> rtl/block_diagonal_matvec.sv
// ----------------------------------------------------------------------------
// block_diagonal_matvec
// Applies a block-diagonal inverse preconditioner to a streamed vector.
// ----------------------------------------------------------------------------
// Load words (opcode 0) write one Q16.16 coefficient of the inverse block
// store. Vector words (opcode 1) are taken one per cycle until the dof
// elements of a node are gathered; the block then computes the dof result
// rows of that node with one shared 32x32 multiplier fed by one read port of
// the coefficient memory, one product per cycle. Each row issues dof
// coefficient reads, then passes the read register, the product register
// and the accumulator; its rounded result is then registered for the result
// channel, which can stall each row. No input is accepted during that work.
// The coefficient memory has no reset and needs no clearing pass; a
// coefficient must be loaded before a node that uses it is computed. Writing
// either register restarts the node and element counters.
// ----------------------------------------------------------------------------
module block_diagonal_matvec
  import bdmv_pkg::*;
#(
  parameter int DOF_MAX  = DOF_MAX_DEF,
  parameter int NODE_MAX = NODE_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PADDR_W-1:0]          paddr,
  input  logic [PDATA_W-1:0]          pwdata,
  output logic [PDATA_W-1:0]          prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [ROW_IDX_W-1:0]        in_row_index,
  input  logic [COL_IDX_W-1:0]        in_col_index,
  input  logic signed [VALUE_W-1:0]   in_value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VALUE_W-1:0]   out_y_value,
  output logic [ROW_IDX_W-1:0]        out_y_index,
  output logic                        out_last
);

  localparam int ROWS   = NODE_MAX * DOF_MAX;
  localparam int DEPTH  = ROWS * DOF_MAX;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KIDX_W = (DOF_MAX > 1) ? $clog2(DOF_MAX) : 1;
  localparam int DCNT_W = $clog2(DOF_MAX + 1);
  localparam int NODE_W = (NODE_MAX > 1) ? $clog2(NODE_MAX) : 1;
  localparam int NCNT_W = $clog2(NODE_MAX + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_WAIT
  } state_t;

  state_t                     state_r;
  logic [DOF_REG_W-1:0]       dof_in_use_r;
  logic [NOD_REG_W-1:0]       nodes_in_use_r;
  logic [KIDX_W-1:0]          element_count_r;
  logic [NODE_W-1:0]          node_count_r;
  logic [ROW_W-1:0]           row_r;
  logic [KIDX_W-1:0]          j_r;
  logic [KIDX_W-1:0]          k_r;
  logic                       v1_r;
  logic                       last1_r;
  logic                       v2_r;
  logic                       last2_r;
  logic                       sum_done_r;
  logic                       out_valid_r;
  logic signed [VALUE_W-1:0]  out_y_value_r;
  logic [ROW_IDX_W-1:0]       out_y_index_r;
  logic                       out_last_r;

  logic [VALUE_W-1:0]         mem [DEPTH];
  logic [VALUE_W-1:0]         rd_data_r;
  logic signed [VALUE_W-1:0]  x_buf_r [DOF_MAX];
  logic [KIDX_W-1:0]          k1_r;
  logic signed [63:0]         prod_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic [DCNT_W-1:0]          dof_eff;
  logic [NCNT_W-1:0]          nodes_eff;
  logic [DCNT_W-1:0]          elem_inc;
  logic [NCNT_W-1:0]          node_inc;
  logic                       in_fire;
  logic                       vec_fire;
  logic                       ld_fire;
  logic                       node_done;
  logic                       cfg_wr;
  logic                       k_last;
  logic                       j_last;
  logic                       out_load;
  logic                       start_row;
  logic [ADDR_W-1:0]          ld_addr;
  logic [ADDR_W-1:0]          rd_addr;
  logic signed [ACC_W-1:0]    rounded;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [VALUE_W-1:0]  y_sat;

  // Out-of-range register values act as the nearest legal size.
  always_comb begin
    if (dof_in_use_r == '0) begin
      dof_eff = DCNT_W'(1);
    end else if (dof_in_use_r > DOF_MAX) begin
      dof_eff = DCNT_W'(DOF_MAX);
    end else begin
      dof_eff = DCNT_W'(dof_in_use_r);
    end
    if (nodes_in_use_r == '0) begin
      nodes_eff = NCNT_W'(1);
    end else if (nodes_in_use_r > NODE_MAX) begin
      nodes_eff = NCNT_W'(NODE_MAX);
    end else begin
      nodes_eff = NCNT_W'(nodes_in_use_r);
    end
  end

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_DOF) ? PDATA_W'(dof_in_use_r) : PDATA_W'(nodes_in_use_r);
  assign cfg_wr   = psel & penable & pwrite;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign vec_fire = in_fire & (in_opcode == OP_VECTOR);
  assign ld_fire  = in_fire & (in_opcode == OP_LOAD) & (in_row_index < ROWS)
                    & (in_col_index < DOF_MAX);

  assign elem_inc  = DCNT_W'(element_count_r) + DCNT_W'(1);
  assign node_inc  = NCNT_W'(node_count_r) + NCNT_W'(1);
  assign node_done = vec_fire & (elem_inc >= dof_eff);
  assign k_last    = (DCNT_W'(k_r) + DCNT_W'(1)) == dof_eff;
  assign j_last    = (DCNT_W'(j_r) + DCNT_W'(1)) == dof_eff;

  assign out_load  = (state_r == S_WAIT) & sum_done_r & (~out_valid_r | out_ready);
  assign start_row = node_done | (out_load & ~j_last);

  assign ld_addr = ADDR_W'(in_row_index * DOF_MAX + in_col_index);
  assign rd_addr = ADDR_W'(row_r * DOF_MAX + k_r);

  // Round to nearest with ties upward, then saturate to Q16.16.
  assign rounded = acc_r + ACC_W'(32768);
  assign shifted = rounded >>> 16;
  always_comb begin
    if (shifted > $signed(ACC_W'(64'sd2147483647))) begin
      y_sat = 32'sh7FFFFFFF;
    end else if (shifted < -$signed(ACC_W'(64'sd2147483648))) begin
      y_sat = 32'sh80000000;
    end else begin
      y_sat = shifted[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      dof_in_use_r    <= DOF_REG_W'(1);
      nodes_in_use_r  <= NOD_REG_W'(1);
      element_count_r <= '0;
      node_count_r    <= '0;
      row_r           <= '0;
      j_r             <= '0;
      k_r             <= '0;
      v1_r            <= 1'b0;
      last1_r         <= 1'b0;
      v2_r            <= 1'b0;
      last2_r         <= 1'b0;
      sum_done_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      v1_r    <= 1'b0;
      v2_r    <= v1_r;
      last2_r <= last1_r;
      if (v2_r && last2_r) begin
        sum_done_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r   <= 1'b1;
        out_y_value_r <= y_sat;
        out_y_index_r <= ROW_IDX_W'(row_r);
        out_last_r    <= j_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (vec_fire) begin
            element_count_r <= node_done ? '0 : KIDX_W'(elem_inc);
          end
          if (node_done) begin
            row_r        <= ROW_W'(node_count_r) * ROW_W'(dof_eff);
            node_count_r <= (node_inc >= nodes_eff) ? '0 : NODE_W'(node_inc);
            j_r          <= '0;
            k_r          <= '0;
            sum_done_r   <= 1'b0;
            state_r      <= S_MAC;
          end
        end
        S_MAC: begin
          v1_r    <= 1'b1;
          last1_r <= k_last;
          k_r     <= k_last ? '0 : k_r + KIDX_W'(1);
          if (k_last) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_load) begin
            if (j_last) begin
              state_r <= S_IDLE;
            end else begin
              j_r        <= j_r + KIDX_W'(1);
              row_r      <= row_r + ROW_W'(1);
              sum_done_r <= 1'b0;
              state_r    <= S_MAC;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // A register write restarts the stream.
      if (cfg_wr) begin
        if (paddr[2] == REG_DOF) begin
          dof_in_use_r <= pwdata[DOF_REG_W-1:0];
        end else begin
          nodes_in_use_r <= pwdata[NOD_REG_W-1:0];
        end
        element_count_r <= '0;
        node_count_r    <= '0;
      end
    end
  end

  // Coefficient memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (ld_fire) begin
      mem[ld_addr] <= in_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vec_fire) begin
      x_buf_r[element_count_r] <= in_value;
    end
  end

  // Multiply stage and exact wide accumulation of one row.
  always_ff @(posedge clk) begin
    if (state_r == S_MAC) begin
      k1_r <= k_r;
    end
    prod_r <= $signed(rd_data_r) * x_buf_r[k1_r];
    if (start_row) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_y_value = out_y_value_r;
  assign out_y_index = out_y_index_r;
  assign out_last    = out_last_r;

endmodule

>>> sim/block_diagonal_matvec_tb.sv
// ----------------------------------------------------------------------------
// block_diagonal_matvec_tb
// Self-checking testbench for the block-diagonal matrix-vector unit. A short
// directed table covers the Q16.16 extremes, saturation, rounding ties,
// out-of-range register values and a small two-by-two block. Random phases
// follow, each with a new block size and node count, streaming vector words
// with coefficient loads mixed in. Both channels idle at random, and once the
// result side holds off long enough to back the block up. Every result word
// is checked against a bit-exact in-bench predictor or a directed table value.
// ----------------------------------------------------------------------------
module block_diagonal_matvec_tb;
  import bdmv_pkg::*;

  localparam int ROWS         = NODE_MAX_DEF * DOF_MAX_DEF;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_PCT     = 31;
  localparam int RAND_WORDS   = 430;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 16;
  localparam int TAIL_CYCLES  = 120;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS   = 40;

  localparam logic signed [ACC_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_LO = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic                 opcode;
    logic [ROW_IDX_W-1:0] row;
    logic [COL_IDX_W-1:0] col;
    logic [VALUE_W-1:0]   value;
    logic                 chk;
    logic [VALUE_W-1:0]   exp_y;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   y;
    logic [ROW_IDX_W-1:0] idx;
    logic                 tail;
  } y_word_t;

  typedef enum logic [1:0] {DIR_LOAD, DIR_VEC, DIR_CFG} dir_kind_e;

  // For register rows, bit 0 of row selects the register and value is the data.
  typedef struct packed {
    dir_kind_e            kind;
    logic [ROW_IDX_W-1:0] row;
    logic [COL_IDX_W-1:0] col;
    logic [VALUE_W-1:0]   value;
    logic                 chk;
    logic [VALUE_W-1:0]   exp_y;
  } dir_row_t;

  localparam int DIR_N = 24;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{DIR_LOAD, 11'd0,    3'd0, 32'h0001_0000, 1'b0, 32'h0},
    '{DIR_VEC,  11'd0,    3'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{DIR_VEC,  11'd0,    3'd0, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{DIR_VEC,  11'd0,    3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{DIR_LOAD, 11'd0,    3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{DIR_VEC,  11'd0,    3'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{DIR_VEC,  11'd0,    3'd0, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{DIR_LOAD, 11'd0,    3'd0, 32'h8000_0000, 1'b0, 32'h0},
    '{DIR_VEC,  11'd0,    3'd0, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
    '{DIR_VEC,  11'd0,    3'd0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
    '{DIR_LOAD, 11'd0,    3'd0, 32'h0000_8000, 1'b0, 32'h0},
    '{DIR_VEC,  11'd0,    3'd0, 32'h0000_0001, 1'b1, 32'h0000_0001},
    '{DIR_VEC,  11'd0,    3'd0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{DIR_VEC,  11'd0,    3'd0, 32'h0000_0003, 1'b1, 32'h0000_0002},
    '{DIR_LOAD, 11'd2047, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{DIR_LOAD, 11'd0,    3'd1, 32'h0001_0000, 1'b0, 32'h0},
    '{DIR_LOAD, 11'd1,    3'd0, 32'h0002_0000, 1'b0, 32'h0},
    '{DIR_LOAD, 11'd1,    3'd1, 32'hFFFF_0000, 1'b0, 32'h0},
    '{DIR_CFG,  11'(REG_DOF),   3'd0, 32'd2, 1'b0, 32'h0},
    '{DIR_CFG,  11'(REG_NODES), 3'd0, 32'd0, 1'b0, 32'h0},
    '{DIR_VEC,  11'd0,    3'd0, 32'h0004_0000, 1'b0, 32'h0},
    '{DIR_VEC,  11'd0,    3'd0, 32'h0001_0000, 1'b0, 32'h0},
    '{DIR_CFG,  11'(REG_DOF),   3'd0, 32'd0, 1'b0, 32'h0},
    '{DIR_VEC,  11'd0,    3'd0, 32'h0002_0000, 1'b1, 32'h0001_0000}
  };

  localparam int N_PRESET = 6;
  localparam logic [DOF_REG_W-1:0] PRE_DOF   [N_PRESET] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd9, 4'd4};
  localparam logic [NOD_REG_W-1:0] PRE_NODES [N_PRESET] = '{9'd2, 9'd256, 9'd1, 9'd511,
                                                            9'd3, 9'd0};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_word_t cur_word  = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_y_value;
  logic [ROW_IDX_W-1:0]      out_y_index;
  logic                      out_last;

  block_diagonal_matvec DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (cur_word.opcode),
    .in_row_index (cur_word.row),
    .in_col_index (cur_word.col),
    .in_value     (cur_word.value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_y_value  (out_y_value),
    .out_y_index  (out_y_index),
    .out_last     (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  logic [VALUE_W-1:0]   coef_mem [ROWS][DOF_MAX_DEF];
  logic [VALUE_W-1:0]   x_buf [DOF_MAX_DEF];
  int unsigned          elem_cnt;
  int unsigned          node_cnt;
  logic [DOF_REG_W-1:0] dof_reg;
  logic [NOD_REG_W-1:0] nodes_reg;

  // Stimulus side: which coefficients have been queued and where the stream
  // will stand once everything queued so far is taken.
  bit          coef_set [ROWS][DOF_MAX_DEF];
  int unsigned gen_elem;
  int unsigned gen_node;
  int unsigned queued_words;

  in_word_t send_q [$];
  y_word_t  y_exp_q [$];
  int       err_cnt    = 0;
  int       acc_words  = 0;
  int       out_words  = 0;
  int       hold_left  = 0;
  bit       hold_done  = 1'b0;
  int       cycles     = 0;
  wire      burst      = (acc_words >= 300) && (acc_words < 380);

  function automatic int unsigned eff_dof(logic [DOF_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > DOF_MAX_DEF) return DOF_MAX_DEF;
    return r;
  endfunction

  function automatic int unsigned eff_nodes(logic [NOD_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > NODE_MAX_DEF) return NODE_MAX_DEF;
    return r;
  endfunction

  // Exact sum of the row's products, rounded half up at bit 16, then clamped.
  function automatic logic [VALUE_W-1:0] row_dot(int unsigned r, int unsigned d);
    logic signed [ACC_W-1:0]   acc;
    logic signed [VALUE_W-1:0] a;
    logic signed [VALUE_W-1:0] x;
    acc = 32768;
    for (int unsigned k = 0; k < d; k++) begin
      a = coef_mem[r][k];
      x = x_buf[k];
      acc = acc + a * x;
    end
    acc = acc >>> 16;
    if (acc > SAT_HI) acc = SAT_HI;
    else if (acc < SAT_LO) acc = SAT_LO;
    return acc[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] rand_q();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom;
      // Within plus or minus 4.0, so sums mostly stay clear of saturation.
      default: return 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
    endcase
  endfunction

  task automatic predict_word(input in_word_t w);
    int unsigned d;
    int unsigned r;
    y_word_t     e;
    if (w.opcode == OP_LOAD) begin
      // With these sizes every row and column index lies inside the store.
      coef_mem[w.row][w.col] = w.value;
    end else begin
      d = eff_dof(dof_reg);
      x_buf[elem_cnt] = w.value;
      elem_cnt++;
      if (elem_cnt >= d) begin
        for (int unsigned j = 0; j < d; j++) begin
          r = node_cnt * d + j;
          e.y = row_dot(r, d);
          e.idx = ROW_IDX_W'(r);
          e.tail = (j == d - 1);
          if (w.chk && e.tail) e.y = w.exp_y;
          y_exp_q.push_back(e);
        end
        elem_cnt = 0;
        node_cnt = (node_cnt + 1 >= eff_nodes(nodes_reg)) ? 0 : node_cnt + 1;
      end
    end
  endtask

  task automatic flag_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("MISMATCH: %s", msg);
    err_cnt++;
  endtask

  task automatic queue_word(input logic op, input logic [ROW_IDX_W-1:0] row,
                            input logic [COL_IDX_W-1:0] col, input logic [VALUE_W-1:0] val,
                            input logic chk, input logic [VALUE_W-1:0] exp_y);
    int unsigned d;
    int unsigned r;
    in_word_t    w;
    d = eff_dof(dof_reg);
    if (op == OP_VECTOR && gen_elem == 0) begin
      // A node reads its whole block, so load whatever is still missing first.
      for (int unsigned j = 0; j < d; j++) begin
        for (int unsigned k = 0; k < d; k++) begin
          r = gen_node * d + j;
          if (!coef_set[r][k]) begin
            w = '{OP_LOAD, ROW_IDX_W'(r), COL_IDX_W'(k), rand_q(), 1'b0, '0};
            send_q.push_back(w);
            coef_set[r][k] = 1'b1;
            queued_words++;
          end
        end
      end
    end
    w = '{op, row, col, val, chk, exp_y};
    send_q.push_back(w);
    queued_words++;
    if (op == OP_LOAD) begin
      coef_set[row][col] = 1'b1;
    end else begin
      gen_elem++;
      if (gen_elem == d) begin
        gen_elem = 0;
        gen_node = (gen_node + 1 >= eff_nodes(nodes_reg)) ? 0 : gen_node + 1;
      end
    end
  endtask

  task automatic cfg_write(input logic idx, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_DOF) dof_reg = data[DOF_REG_W-1:0];
    else nodes_reg = data[NOD_REG_W-1:0];
    // Any register write restarts the stream at element 0 of node 0.
    elem_cnt = 0;
    node_cnt = 0;
    gen_elem = 0;
    gen_node = 0;
    @(negedge clk);
  endtask

  // Registers change only once every queued word is taken, every result is
  // back and a settling wait has passed for trailing loads to land.
  task automatic wait_idle();
    while (send_q.size() != 0 || in_valid || y_exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_q.size() != 0 && (burst || $urandom_range(99) >= IDLE_PCT)) begin
        cur_word <= send_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side; the one long hold-off lets the block fill and stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && acc_words >= 200 && send_q.size() > 4) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= burst || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : scoreboard
    y_word_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (y_exp_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d y=%h idx=%0d last=%0b with nothing expected",
                                  out_words, out_y_value, out_y_index, out_last));
        end else begin
          e = y_exp_q.pop_front();
          if (out_y_value !== e.y || out_y_index !== e.idx || out_last !== e.tail)
            flag_mismatch($sformatf("result %0d got y=%h idx=%0d last=%0b, exp y=%h idx=%0d last=%0b",
                                    out_words, out_y_value, out_y_index, out_last,
                                    e.y, e.idx, e.tail));
        end
        out_words <= out_words + 1;
      end
      if (in_valid && in_ready) begin
        predict_word(cur_word);
        acc_words <= acc_words + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned          base;
    int unsigned          phase;
    int unsigned          d;
    int unsigned          n_elem;
    logic [DOF_REG_W-1:0] dsel;
    logic [NOD_REG_W-1:0] nsel;
    dof_reg      = 4'd1;
    nodes_reg    = 9'd1;
    elem_cnt     = 0;
    node_cnt     = 0;
    gen_elem     = 0;
    gen_node     = 0;
    queued_words = 0;
    for (int i = 0; i < DOF_MAX_DEF; i++) x_buf[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      case (DIR_TAB[i].kind)
        DIR_CFG: begin
          wait_idle();
          cfg_write(DIR_TAB[i].row[0], DIR_TAB[i].value);
        end
        DIR_LOAD: queue_word(OP_LOAD, DIR_TAB[i].row, DIR_TAB[i].col, DIR_TAB[i].value,
                             DIR_TAB[i].chk, DIR_TAB[i].exp_y);
        default: queue_word(OP_VECTOR, DIR_TAB[i].row, DIR_TAB[i].col, DIR_TAB[i].value,
                            DIR_TAB[i].chk, DIR_TAB[i].exp_y);
      endcase
    end

    base  = queued_words;
    phase = 0;
    while (queued_words - base < RAND_WORDS) begin
      wait_idle();
      if (phase < N_PRESET) begin
        dsel = PRE_DOF[phase];
        nsel = PRE_NODES[phase];
      end else begin
        dsel = ($urandom_range(3) == 0) ? DOF_REG_W'($urandom_range(15))
                                        : DOF_REG_W'($urandom_range(1, 4));
        nsel = ($urandom_range(3) == 0) ? NOD_REG_W'($urandom_range(511))
                                        : NOD_REG_W'($urandom_range(1, 6));
      end
      cfg_write(REG_DOF, PDATA_W'(dsel));
      cfg_write(REG_NODES, PDATA_W'(nsel));
      d = eff_dof(dof_reg);
      // Large blocks cost d*d loads per new node, so they run only a node or two.
      n_elem = d * ((d >= 5) ? $urandom_range(1, 2) : $urandom_range(1, 10))
             + $urandom_range(0, d - 1);
      for (int unsigned i = 0; i < n_elem; i++) begin
        if ($urandom_range(7) == 0)
          queue_word(OP_LOAD, ROW_IDX_W'($urandom), COL_IDX_W'($urandom), rand_q(),
                     1'b0, '0);
        queue_word(OP_VECTOR, ROW_IDX_W'($urandom), COL_IDX_W'($urandom), rand_q(),
                   1'b0, '0);
      end
      phase++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bdmv_pkg.sv
rtl/block_diagonal_matvec.sv
sim/block_diagonal_matvec_tb.sv
